### src/gbba_pkg.sv
// Shared types and constants for the group bitmap block allocator.
package gbba_pkg;

    localparam int IN_DATA_W   = 64;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 40;
    localparam int OUT_USER_W  = 1;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int BLK_W       = 17;
    localparam int CNT_W       = 14;
    localparam int TOTAL_W     = 17;
    localparam int BPG_W       = 14;
    localparam int GIU_W       = 4;

    localparam logic [CNT_W-1:0] GROUP_COUNT_MAX = 14'h3FFF;

    typedef enum logic [1:0] {
        MODE_LOAD_WORD  = 2'd0,
        MODE_LOAD_COUNT = 2'd1,
        MODE_LOAD_TOTAL = 2'd2,
        MODE_ALLOC      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_FIRST_DATA_BLOCK = 2'd0,
        REG_BLOCKS_PER_GROUP = 2'd1,
        REG_GROUPS_IN_USE    = 2'd2,
        REG_NONE             = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

### src/group_bitmap_block_allocator.sv
// Top level of the first-fit group bitmap block allocator.
//
// Input items arrive on the s_ stream; mode in s_tuser selects a load of a
// bitmap word, a group free count, the total free count, or an allocation.
// Every item returns exactly one result item on the m_ stream: block number,
// success flag and the total free count after the item.
// A load item is applied on acceptance and its result passes through the
// response state to the output register. An allocation walks the groups in
// order with one word compare unit fed by the bitmap RAM read port, one word
// per cycle, skipping groups with a zero free count; WPG is the bitmap words
// per group.
// s_tready is high only while no item is in work; the result waits in an
// output register, so a new item is accepted while it is still pending, and
// the next result waits until the receiver takes the previous one.
// Configuration goes through the APB port; the user writes it only while idle,
// which the block does not enforce. Reset clears free counts, total, output
// valid and restores register defaults; bitmap words are undefined until loaded.
module group_bitmap_block_allocator #(
    parameter int GROUPS         = 8,
    parameter int BITS_PER_GROUP = 8192
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // group[2:0], word_index[10:3], word_data[42:11], count_value[59:43]
    input  logic [gbba_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  logic [gbba_pkg::IN_USER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // block_number[16:0], total_free[33:17]
    output logic [gbba_pkg::OUT_DATA_W-1:0]    m_tdata,
    // success[0]
    output logic [gbba_pkg::OUT_USER_W-1:0]    m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gbba_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [gbba_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [gbba_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready
);

    import gbba_pkg::*;

    localparam int WPG   = (BITS_PER_GROUP + 31) / 32;
    localparam int DEPTH = GROUPS * WPG;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(WPG + 1);
    localparam int GW    = $clog2(GROUPS + 1);
    localparam int GIW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LW    = $clog2(BITS_PER_GROUP + 1);

    state_t               state_reg, state_next;
    logic [GW-1:0]        g_reg, g_next;
    logic [BLK_W-1:0]     gbase_reg, gbase_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [WW-1:0]        wrd_reg, wrd_next;
    logic [WW-1:0]        wchk_reg, wchk_next;
    logic                 chk_v_reg, chk_v_next;
    logic [AW-1:0]        chk_addr_reg, chk_addr_next;
    logic [BLK_W-1:0]     res_blk_reg, res_blk_next;
    logic                 res_ok_reg, res_ok_next;
    logic                 m_valid_reg, m_valid_next;
    logic [BLK_W-1:0]     m_blk_reg, m_blk_next;
    logic                 m_ok_reg, m_ok_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;
    logic [CNT_W-1:0]     cnt_reg [GROUPS];
    logic [CNT_W-1:0]     cnt_next [GROUPS];
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 fdb_reg;
    logic [BPG_W-1:0]     bpg_reg;
    logic [GIU_W-1:0]     giu_reg;

    logic                 s_fire;
    mode_t                in_mode;
    logic [2:0]           in_group;
    logic [7:0]           in_widx;
    logic [31:0]          in_word;
    logic [TOTAL_W-1:0]   in_count;
    logic                 load_grp_ok;
    logic [GIW-1:0]       load_gi;
    logic [AW-1:0]        load_addr;

    logic [LW-1:0]        limit;
    logic [WW-1:0]        nwords;
    logic [GW-1:0]        ng;
    logic [GIW-1:0]       gi;
    logic                 grp_done;
    logic                 grp_skip;
    logic                 issue;
    logic [AW-1:0]        rd_addr;
    logic [31:0]          mask;
    logic [31:0]          inv;
    logic [31:0]          onehot;
    logic [4:0]           bidx;
    logic                 found;
    logic                 out_free;
    logic                 cfg_we;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [31:0]          ram_wdata;
    logic [31:0]          ram_rdata;

    assign s_fire    = s_tvalid && s_tready;
    assign in_mode   = mode_t'(s_tuser);
    assign in_group  = s_tdata[2:0];
    assign in_widx   = s_tdata[10:3];
    assign in_word   = s_tdata[42:11];
    assign in_count  = s_tdata[59:43];
    assign load_grp_ok = 32'(in_group) < GROUPS;
    assign load_gi   = GIW'(in_group);
    assign load_addr = AW'(32'(in_group) * WPG + 32'(in_widx));

    assign limit  = (32'(bpg_reg) > BITS_PER_GROUP) ? LW'(BITS_PER_GROUP) : LW'(bpg_reg);
    assign nwords = WW'((32'(limit) + 32'd31) >> 5);
    assign ng     = (32'(giu_reg) > GROUPS) ? GW'(GROUPS) : GW'(giu_reg);
    assign gi     = g_reg[GIW-1:0];

    assign grp_done = g_reg >= ng;
    assign grp_skip = (cnt_reg[gi] == '0) || (nwords == '0);
    assign issue    = wrd_reg < nwords;
    assign rd_addr  = base_reg + AW'(wrd_reg);

    assign mask   = ((wchk_reg == nwords - WW'(1)) && (limit[4:0] != 5'd0))
                  ? ~(32'hFFFF_FFFF << limit[4:0]) : 32'hFFFF_FFFF;
    assign inv    = ~ram_rdata & mask;
    assign onehot = inv & (~inv + 32'd1);
    assign found  = (state_reg == ST_SCAN) && chk_v_reg && (inv != '0);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        bidx = '0;
        for (int b = 0; b < 32; b++) begin
            if (onehot[b]) begin
                bidx = bidx | 5'(b);
            end
        end
    end

    gbba_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (in_mode == MODE_ALLOC) ? ST_GROUP : ST_RESP;
                end
            end
            ST_GROUP: begin
                if (grp_done) begin
                    state_next = ST_RESP;
                end else if (!grp_skip) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (found) begin
                    state_next = ST_RESP;
                end else if (!chk_v_reg && !issue) begin
                    state_next = ST_GROUP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        g_next        = g_reg;
        gbase_next    = gbase_reg;
        base_next     = base_reg;
        wrd_next      = wrd_reg;
        wchk_next     = wchk_reg;
        chk_v_next    = chk_v_reg;
        chk_addr_next = chk_addr_reg;
        res_blk_next  = res_blk_reg;
        res_ok_next   = res_ok_reg;
        m_blk_next    = m_blk_reg;
        m_ok_next     = m_ok_reg;
        m_total_next  = m_total_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        ram_we        = 1'b0;
        ram_waddr     = load_addr;
        ram_wdata     = in_word;
        s_tready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    res_blk_next = '0;
                    res_ok_next  = 1'b0;
                    g_next       = '0;
                    gbase_next   = '0;
                    base_next    = '0;
                    unique case (in_mode)
                        MODE_LOAD_WORD: begin
                            if (load_grp_ok && (32'(in_widx) < WPG)) begin
                                ram_we      = 1'b1;
                                res_ok_next = 1'b1;
                            end
                        end
                        MODE_LOAD_COUNT: begin
                            if (load_grp_ok) begin
                                cnt_next[load_gi] = (in_count > TOTAL_W'(GROUP_COUNT_MAX))
                                                  ? GROUP_COUNT_MAX : in_count[CNT_W-1:0];
                                res_ok_next = 1'b1;
                            end
                        end
                        MODE_LOAD_TOTAL: begin
                            total_next  = in_count;
                            res_ok_next = 1'b1;
                        end
                        MODE_ALLOC: begin
                        end
                    endcase
                end
            end
            ST_GROUP: begin
                wrd_next   = '0;
                chk_v_next = 1'b0;
                if (!grp_done && grp_skip) begin
                    g_next     = g_reg + GW'(1);
                    gbase_next = gbase_reg + BLK_W'(limit);
                    base_next  = base_reg + AW'(WPG);
                end
            end
            ST_SCAN: begin
                chk_v_next = issue;
                if (issue) begin
                    wrd_next      = wrd_reg + WW'(1);
                    wchk_next     = wrd_reg;
                    chk_addr_next = rd_addr;
                end
                if (found) begin
                    ram_we       = 1'b1;
                    ram_waddr    = chk_addr_reg;
                    ram_wdata    = ram_rdata | onehot;
                    cnt_next[gi] = cnt_reg[gi] - CNT_W'(1);
                    if (total_reg != '0) begin
                        total_next = total_reg - TOTAL_W'(1);
                    end
                    res_blk_next = BLK_W'(fdb_reg) + gbase_reg
                                 + BLK_W'({wchk_reg, bidx});
                    res_ok_next  = 1'b1;
                end else if (!chk_v_reg && !issue) begin
                    g_next     = g_reg + GW'(1);
                    gbase_next = gbase_reg + BLK_W'(limit);
                    base_next  = base_reg + AW'(WPG);
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_blk_next   = res_blk_reg;
                    m_ok_next    = res_ok_reg;
                    m_total_next = total_reg;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            chk_v_reg   <= 1'b0;
            g_reg       <= '0;
            wrd_reg     <= '0;
            for (int i = 0; i < GROUPS; i++) begin
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            chk_v_reg   <= chk_v_next;
            g_reg       <= g_next;
            wrd_reg     <= wrd_next;
            for (int i = 0; i < GROUPS; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        gbase_reg    <= gbase_next;
        base_reg     <= base_next;
        wchk_reg     <= wchk_next;
        chk_addr_reg <= chk_addr_next;
        res_blk_reg  <= res_blk_next;
        res_ok_reg   <= res_ok_next;
        m_blk_reg    <= m_blk_next;
        m_ok_reg     <= m_ok_next;
        m_total_reg  <= m_total_next;
    end

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fdb_reg <= 1'b1;
            bpg_reg <= BPG_W'(8192);
            giu_reg <= GIU_W'(8);
        end else if (cfg_we) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_FIRST_DATA_BLOCK: fdb_reg <= pwdata[0];
                REG_BLOCKS_PER_GROUP: bpg_reg <= pwdata[BPG_W-1:0];
                REG_GROUPS_IN_USE:    giu_reg <= pwdata[GIU_W-1:0];
                REG_NONE: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx_t'(paddr[3:2]))
            REG_FIRST_DATA_BLOCK: prdata = CFG_DATA_W'(fdb_reg);
            REG_BLOCKS_PER_GROUP: prdata = CFG_DATA_W'(bpg_reg);
            REG_GROUPS_IN_USE:    prdata = CFG_DATA_W'(giu_reg);
            REG_NONE:             prdata = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_total_reg, m_blk_reg};
    assign m_tuser  = m_ok_reg;

endmodule

### src/gbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/gbba_checker.sv
// Port-level checker for the group bitmap block allocator, with its bind.
module gbba_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [gbba_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [gbba_pkg::OUT_USER_W-1:0]  m_tuser
);

    import gbba_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[BLK_W-1:0] == '0)
        else $error("failed item carries a block number");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item in work");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind group_bitmap_block_allocator gbba_checker u_gbba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the group bitmap block allocator: directed and random items.

localparam int TB_GROUPS  = 8;
localparam int TB_BPG_MAX = 8192;
localparam int TB_WPG     = TB_BPG_MAX / 32;

typedef struct packed {
    logic [16:0] block_number;
    logic        success;
    logic [16:0] total_free;
} alloc_reply_t;

class alloc_scoreboard;
    logic [31:0]  bitmap [TB_GROUPS*TB_WPG];
    bit           loaded [TB_GROUPS*TB_WPG];
    logic [13:0]  group_free [TB_GROUPS];
    logic [16:0]  total_free;
    logic         first_block;
    logic [13:0]  group_size;
    logic [3:0]   groups_in_use;
    alloc_reply_t replies_due[$];
    int           errors;

    function new();
        foreach (bitmap[i]) begin
            bitmap[i] = '0;
            loaded[i] = 1'b0;
        end
        foreach (group_free[i]) group_free[i] = '0;
        total_free       = '0;
        first_block      = 1'b1;
        group_size       = 14'd8192;
        groups_in_use    = 4'd8;
        errors           = 0;
    endfunction

    function int scan_limit();
        return (group_size > TB_BPG_MAX) ? TB_BPG_MAX : int'(group_size);
    endfunction

    function int scan_groups();
        return (groups_in_use > TB_GROUPS) ? TB_GROUPS : int'(groups_in_use);
    endfunction

    // bitmap word that an allocation would read before it was ever loaded
    function int first_unwritten();
        int words;
        words = (scan_limit() + 31) / 32;
        for (int g = 0; g < scan_groups(); g++)
            if (group_free[g] != 0)
                for (int w = 0; w < words; w++)
                    if (!loaded[g*TB_WPG + w]) return g*TB_WPG + w;
        return -1;
    endfunction

    function void set_register(gbba_pkg::reg_idx_t idx, logic [31:0] value);
        case (idx)
            gbba_pkg::REG_FIRST_DATA_BLOCK: first_block      = value[0];
            gbba_pkg::REG_BLOCKS_PER_GROUP: group_size       = value[13:0];
            gbba_pkg::REG_GROUPS_IN_USE:    groups_in_use    = value[3:0];
            default: ;
        endcase
    endfunction

    function void note_item(gbba_pkg::mode_t mode, logic [2:0] grp, logic [7:0] widx,
                            logic [31:0] data, logic [16:0] cnt);
        alloc_reply_t r;
        int           lim;
        int           words;
        int           bitpos;
        int           slot;
        logic [31:0]  inv;
        r     = '0;
        lim   = scan_limit();
        words = (lim + 31) / 32;
        case (mode)
            gbba_pkg::MODE_LOAD_WORD: begin
                slot         = int'(grp) * TB_WPG + int'(widx);
                bitmap[slot] = data;
                loaded[slot] = 1'b1;
                r.success    = 1'b1;
            end
            gbba_pkg::MODE_LOAD_COUNT: begin
                group_free[grp] = (cnt > gbba_pkg::GROUP_COUNT_MAX) ?
                                  gbba_pkg::GROUP_COUNT_MAX : cnt[13:0];
                r.success = 1'b1;
            end
            gbba_pkg::MODE_LOAD_TOTAL: begin
                total_free = cnt;
                r.success  = 1'b1;
            end
            default: begin
                for (int g = 0; g < scan_groups() && !r.success; g++) begin
                    if (group_free[g] != 0) begin
                        bitpos = -1;
                        for (int w = 0; w < words && bitpos < 0; w++) begin
                            inv = ~bitmap[g*TB_WPG + w];
                            if (lim - w*32 < 32) inv &= (32'h1 << (lim - w*32)) - 32'h1;
                            for (int b = 0; b < 32 && bitpos < 0; b++)
                                if (inv[b]) bitpos = w*32 + b;
                        end
                        if (bitpos >= 0) begin
                            bitmap[g*TB_WPG + bitpos/32][bitpos%32] = 1'b1;
                            group_free[g] = group_free[g] - 14'd1;
                            if (total_free != 0) total_free = total_free - 17'd1;
                            r.block_number = 17'(int'(first_block) + g*lim + bitpos);
                            r.success      = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.total_free = total_free;
        replies_due.push_back(r);
    endfunction

    function void check_result(logic [16:0] blk, logic ok, logic [16:0] tot);
        alloc_reply_t want;
        if (replies_due.size() == 0) begin
            $display("%t: unexpected result block_number %0d success %0b total_free %0d",
                     $time, blk, ok, tot);
            errors++;
            return;
        end
        want = replies_due.pop_front();
        if (want.block_number !== blk) begin
            $display("%t: block_number expected %0d actual %0d", $time, want.block_number, blk);
            errors++;
        end
        if (want.success !== ok) begin
            $display("%t: success expected %0b actual %0b", $time, want.success, ok);
            errors++;
        end
        if (want.total_free !== tot) begin
            $display("%t: total_free expected %0d actual %0d", $time, want.total_free, tot);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import gbba_pkg::*;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int tx_idle_pct = 29;
    int rx_idle_pct = 76;

    alloc_scoreboard sb = new();

    group_bitmap_block_allocator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[16:0], m_tuser[0], m_tdata[33:17]);
    end

    task automatic send_item(mode_t mode, logic [2:0] grp, logic [7:0] widx,
                             logic [31:0] data, logic [16:0] cnt);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, cnt, data, widx, grp};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(mode, grp, widx, data, cnt);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(posedge aclk);
    endtask

    task automatic set_config(logic fdb, logic [13:0] bpg, logic [3:0] giu);
        write_reg(REG_FIRST_DATA_BLOCK, 32'(fdb));
        write_reg(REG_BLOCKS_PER_GROUP, 32'(bpg));
        write_reg(REG_GROUPS_IN_USE, 32'(giu));
    endtask

    // drop valid and hold until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_item();
        int          pick;
        int          nw;
        int          miss;
        mode_t       mode;
        logic [2:0]  grp;
        logic [7:0]  widx;
        logic [31:0] data;
        logic [16:0] cnt;
        pick = $urandom_range(0, 99);
        nw   = (sb.scan_limit() + 31) / 32;
        grp  = 3'($urandom_range(0, 7));
        widx = 8'((nw > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, nw - 1)
                                                        : $urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       data = $urandom | $urandom;
            1:       data = '1;
            2:       data = $urandom;
            default: data = $urandom & $urandom;
        endcase
        cnt = 17'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                             : $urandom_range(0, 131071));
        if (pick < 45)      mode = MODE_ALLOC;
        else if (pick < 75) mode = MODE_LOAD_WORD;
        else if (pick < 92) mode = MODE_LOAD_COUNT;
        else                mode = MODE_LOAD_TOTAL;
        // load any bitmap word the scan would reach before allocating
        if (mode == MODE_ALLOC) begin
            miss = sb.first_unwritten();
            if (miss >= 0) begin
                mode = MODE_LOAD_WORD;
                grp  = 3'(miss / TB_WPG);
                widx = 8'(miss % TB_WPG);
            end
        end
        send_item(mode, grp, widx, data, cnt);
    endtask

    initial begin
        logic [13:0] bpg_val;
        logic [3:0]  giu_val;
        int          idx;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_LOAD_TOTAL, 3'd0, 8'd0, '0, 17'h10000);
        drain();
        set_config(1'b0, 14'd32, 4'd8);
        send_item(MODE_LOAD_WORD, 3'd0, 8'd0, 32'h0000_0000, '0);
        send_item(MODE_LOAD_WORD, 3'd1, 8'd0, 32'hFFFF_FFFF, '0);
        send_item(MODE_LOAD_WORD, 3'd2, 8'd0, 32'h7FFF_FFFF, '0);
        send_item(MODE_LOAD_WORD, 3'd3, 8'd0, 32'hFFFF_0000, '0);
        send_item(MODE_LOAD_COUNT, 3'd0, 8'd0, '0, 17'd1);
        send_item(MODE_LOAD_COUNT, 3'd1, 8'd0, '0, 17'h1FFFF);
        send_item(MODE_LOAD_COUNT, 3'd2, 8'd0, '0, 17'd5);
        send_item(MODE_LOAD_COUNT, 3'd3, 8'd0, '0, 17'd2);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_LOAD_TOTAL, 3'd0, 8'd0, '0, 17'd0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_LOAD_WORD, 3'd7, 8'd255, 32'hFFFF_FFFF, '0);
        drain();
        set_config(1'b1, 14'd0, 4'd8);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        drain();
        set_config(1'b1, 14'd32, 4'd0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        drain();
        set_config(1'b1, 14'd33, 4'd15);
        send_item(MODE_LOAD_WORD, 3'd1, 8'd1, 32'hFFFF_FFFE, '0);
        send_item(MODE_LOAD_WORD, 3'd2, 8'd1, 32'hFFFF_FFFF, '0);
        send_item(MODE_LOAD_WORD, 3'd3, 8'd1, 32'hFFFF_FFFE, '0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);

        // oversized group size: group 1 starts at the largest group size
        drain();
        set_config(1'b1, 14'h3FFF, 4'd15);
        send_item(MODE_LOAD_COUNT, 3'd0, 8'd0, '0, 17'd0);
        send_item(MODE_LOAD_COUNT, 3'd1, 8'd0, '0, 17'd2);
        send_item(MODE_LOAD_WORD, 3'd1, 8'd0, 32'h0000_FFFF, '0);
        send_item(MODE_LOAD_TOTAL, 3'd0, 8'd0, '0, 17'h1FFFF);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);
        send_item(MODE_ALLOC, 3'd0, 8'd0, '0, '0);

        for (int seg = 0; seg < 6; seg++) begin
            drain();
            case ($urandom_range(0, 9))
                0:       bpg_val = 14'd1;
                1:       bpg_val = 14'd31;
                2:       bpg_val = 14'd32;
                3:       bpg_val = 14'd33;
                4:       bpg_val = 14'd64;
                5:       bpg_val = 14'd96;
                6:       bpg_val = 14'd100;
                7:       bpg_val = 14'd128;
                8:       bpg_val = 14'($urandom_range(1, 160));
                default: bpg_val = 14'($urandom_range(2, 64));
            endcase
            giu_val = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, 8));
            set_config(1'($urandom_range(0, 1)), bpg_val, giu_val);
            for (int i = 0; i < 44; i++) begin
                idx = seg * 44 + i;
                if (idx < 88) begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 76;
                end else if (idx < 176) begin
                    tx_idle_pct = 76;
                    rx_idle_pct = 29;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                random_item();
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.replies_due.size() == 0)
            $display("PASS group_bitmap_block_allocator");
        else
            $display("FAIL group_bitmap_block_allocator");
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("FAIL group_bitmap_block_allocator");
        $finish;
    end
endmodule
